// ===== hdl/ckms_pkg.sv =====
// Shared constants and types for the nearest-key search block.
package ckms_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_W        = 24;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 2 * ID_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic start;
		logic valid;
	} scan_ctl_t;

	typedef struct packed {
		logic busy;
		logic found;
	} scan_sts_t;

endpackage

// ===== hdl/ckms_if.sv =====
// Valid/ready channel interfaces for request and result beats.
interface ckms_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [ckms_pkg::ID_W-1:0] load_id;
	logic [ckms_pkg::ID_W-1:0] load_size;
	logic [ckms_pkg::ID_W-1:0] want_id;
	logic [ckms_pkg::ID_W-1:0] want_min_size;

	modport source (output valid, mode, load_id, load_size, want_id, want_min_size,
		input ready);
	modport sink (input valid, mode, load_id, load_size, want_id, want_min_size,
		output ready);
endinterface

interface ckms_out_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [ckms_pkg::ID_W-1:0] best_id;

	modport source (output valid, found, best_id, input ready);
	modport sink (input valid, found, best_id, output ready);
endinterface

// ===== hdl/ckms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ckms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/ckms_scan.sv =====
// Two-stage distance and best-candidate tracker fed one entry per cycle.
module ckms_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ckms_pkg::scan_ctl_t       ctl,
	input  ckms_pkg::entry_t          entry,
	input  logic [ckms_pkg::ID_W-1:0] want_id,
	input  logic [ckms_pkg::ID_W-1:0] want_min_size,
	output ckms_pkg::scan_sts_t       sts,
	output logic [ckms_pkg::ID_W-1:0] best_id
);
	import ckms_pkg::*;

	logic [ID_W-1:0] want_q;
	logic [ID_W-1:0] min_q;
	logic            valid_s1;
	logic            qual_s1;
	logic [ID_W-1:0] id_s1;
	logic [ID_W-1:0] dist_s1;
	logic            have_q;
	logic [ID_W-1:0] best_q;
	logic [ID_W-1:0] best_dist_q;
	logic [ID_W-1:0] span;
	logic            better;

	assign span = (entry.id >= want_q) ? (entry.id - want_q) : (want_q - entry.id);

	assign better = !have_q || (dist_s1 < best_dist_q) ||
		((dist_s1 == best_dist_q) && (id_s1 < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			have_q   <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
			if (ctl.start) begin
				have_q <= 1'b0;
			end else if (valid_s1 && qual_s1) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			want_q <= want_id;
			min_q  <= want_min_size;
		end
		qual_s1 <= entry.size >= min_q;
		id_s1   <= entry.id;
		dist_s1 <= span;
		if (valid_s1 && qual_s1 && better) begin
			best_q      <= id_s1;
			best_dist_q <= dist_s1;
		end
	end

	assign sts.busy  = valid_s1;
	assign sts.found = have_q;
	assign best_id   = have_q ? best_q : '0;
endmodule

// ===== hdl/closest_key_with_min_size.sv =====
// Top level: entry table, scan sequencer and result register.
//
//   channel  | role | beat carries
//   ---------+------+---------------------------------------------------
//   item     | sink | mode, load_id, load_size, want_id, want_min_size
//   result   | src  | found, best_id (one beat per query)
//
// Load and clear are done as they are taken; a query scans the table through the
// single read port of the entry RAM, one entry per cycle (an empty table skips
// the scan).
// Reset empties the table at once; RAM contents are not cleared.
// A finished answer waits in the result register while new beats are taken;
// a later query holds in its last step until that register frees.
module closest_key_with_min_size (
	input  logic       clk,
	input  logic       arst_n,
	ckms_in_if.sink    item,
	ckms_out_if.source result
);
	import ckms_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_q;
	logic             res_valid_q;
	logic             found_q;
	logic [ID_W-1:0]  best_q;

	logic             acc;
	logic             is_load;
	logic             is_query;
	logic             is_clear;
	logic             we;
	logic             re;
	logic             last;
	logic             res_load;
	entry_t           wr_entry;
	logic [ENTRY_W-1:0] rd_word;
	entry_t           rd_entry;
	scan_ctl_t        ctl;
	scan_sts_t        sts;
	logic [ID_W-1:0]  scan_best;

	assign item.ready = (state_q == S_IDLE);
	assign acc        = item.valid && item.ready;

	always_comb begin
		is_load  = 1'b0;
		is_query = 1'b0;
		is_clear = 1'b0;
		case (item.mode)
			MODE_LOAD:  is_load  = acc;
			MODE_QUERY: is_query = acc;
			MODE_CLEAR: is_clear = acc;
			default:    ;
		endcase
	end

	assign we            = is_load && (count_q < CNT_FULL);
	assign re            = (state_q == S_SCAN);
	assign last          = (CNT_W'(rd_idx_q + 1'b1) == count_q);
	assign res_load      = (state_q == S_DONE) && (!res_valid_q || result.ready);
	assign wr_entry.id   = item.load_id;
	assign wr_entry.size = item.load_size;
	assign rd_entry      = rd_word;
	assign ctl.start     = is_query;
	assign ctl.valid     = rd_vld_q;

	ckms_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (re),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_word)
	);

	ckms_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.entry         (rd_entry),
		.want_id       (item.want_id),
		.want_min_size (item.want_min_size),
		.sts           (sts),
		.best_id       (scan_best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
		end else begin
			rd_vld_q <= re;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (we) begin
						count_q <= CNT_W'(count_q + 1'b1);
					end
					if (is_clear) begin
						count_q <= '0;
					end
					if (is_query) begin
						rd_idx_q <= '0;
						state_q  <= (count_q == '0) ? S_DRAIN : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
					if (last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_q && !sts.busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						found_q <= sts.found;
						best_q  <= scan_best;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid   = res_valid_q;
	assign result.found   = found_q;
	assign result.best_id = best_q;
endmodule

// ===== tb/tb_closest_key_with_min_size.sv =====
// Self-checking testbench for the nearest-key search block with a size threshold.
module tb_closest_key_with_min_size;
	import ckms_pkg::*;

	localparam logic [1:0]      MODE_UNUSED  = 2'd3;
	localparam logic [ID_W-1:0] ID_MAX       = '1;
	localparam int              RANDOM_ITEMS = 530;
	localparam int              IDLE_LIMIT   = 5000;
	localparam int              HOLD_CYCLES  = 400;
	localparam int              HOLD_AFTER   = 250;

	typedef struct packed {
		logic [1:0]      mode;
		logic [ID_W-1:0] load_id;
		logic [ID_W-1:0] load_size;
		logic [ID_W-1:0] want_id;
		logic [ID_W-1:0] want_min_size;
		logic            fixed;
		logic            fix_found;
		logic [ID_W-1:0] fix_best_id;
	} request_t;

	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] best_id;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	ckms_in_if  item_ch ();
	ckms_out_if result_ch ();

	closest_key_with_min_size dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	request_t        stimulus [$];
	answer_t         pending_answers [$];
	logic [ID_W-1:0] key_ids [TABLE_DEPTH];
	logic [ID_W-1:0] key_sizes [TABLE_DEPTH];
	int              key_count   = 0;
	int              taken       = 0;
	int              fail_count  = 0;
	int              idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [ID_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ID_MAX;
			2: return ID_W'($urandom_range(0, 15));
			default: return ID_W'($urandom);
		endcase
	endfunction

	function automatic request_t stray_fields();
		request_t r;
		r = '0;
		r.load_id       = pick_value();
		r.load_size     = pick_value();
		r.want_id       = pick_value();
		r.want_min_size = pick_value();
		return r;
	endfunction

	function automatic void add_row(request_t r);
		stimulus = {stimulus, r};
	endfunction

	function automatic answer_t nearest_fit(logic [ID_W-1:0] want, logic [ID_W-1:0] min_size);
		answer_t         ans;
		logic [ID_W-1:0] span;
		logic [ID_W-1:0] best_dist;
		ans = '0;
		best_dist = '0;
		for (int i = 0; i < key_count; i++) begin
			if (key_sizes[i] >= min_size) begin
				span = (key_ids[i] >= want) ? key_ids[i] - want : want - key_ids[i];
				if (!ans.found || span < best_dist ||
						(span == best_dist && key_ids[i] < ans.best_id)) begin
					ans.found   = 1'b1;
					ans.best_id = key_ids[i];
					best_dist   = span;
				end
			end
		end
		return ans;
	endfunction

	function automatic void build_stimulus();
		request_t        rows [24];
		request_t        r;
		int              counted;
		int              nloads;
		int              nq;
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] last_size;
		bit              narrow;
		bit              first;
		rows = '{
			'{MODE_QUERY,  24'h0,   24'h0,   24'h0,   24'h0,   1'b1, 1'b0, 24'h0},
			'{MODE_QUERY,  ID_MAX,  ID_MAX,  ID_MAX,  ID_MAX,  1'b1, 1'b0, 24'h0},
			'{MODE_CLEAR,  24'h0,   24'h0,   24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_UNUSED, ID_MAX,  ID_MAX,  ID_MAX,  ID_MAX,  1'b0, 1'b0, 24'h0},
			'{MODE_LOAD,   24'h0,   ID_MAX,  24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_LOAD,   ID_MAX,  24'h0,   24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'h0,   24'h0,   1'b1, 1'b1, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   ID_MAX,  24'h0,   1'b1, 1'b1, ID_MAX},
			'{MODE_QUERY,  24'h0,   24'h0,   ID_MAX,  24'h1,   1'b1, 1'b1, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   ID_MAX,  ID_MAX,  1'b1, 1'b1, 24'h0},
			'{MODE_LOAD,   24'd100, 24'd50,  24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_LOAD,   24'd110, 24'd50,  24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'd105, 24'd50,  1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'd105, 24'd51,  1'b0, 1'b0, 24'h0},
			'{MODE_LOAD,   24'd100, 24'd60,  24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'd99,  24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 24'h0},
			'{MODE_LOAD,   24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'hAAAAAA, 24'h555555, 24'h555556, 24'hAAAAAA, 1'b0, 1'b0, 24'h0},
			'{MODE_UNUSED, 24'h0,   24'h0,   24'h0,   24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_CLEAR,  ID_MAX,  ID_MAX,  ID_MAX,  ID_MAX,  1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'd100, 24'h0,   1'b1, 1'b0, 24'h0},
			'{MODE_LOAD,   24'h123456, 24'h0, 24'h0,  24'h0,   1'b0, 1'b0, 24'h0},
			'{MODE_QUERY,  24'h0,   24'h0,   24'h0,   24'h0,   1'b0, 1'b0, 24'h0}
		};
		foreach (rows[i])
			add_row(rows[i]);

		counted = 0;
		first = 1'b1;
		last_size = '0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				r = stray_fields();
				r.mode = MODE_UNUSED;
				add_row(r);
			end else begin
				if (first || $urandom_range(0, 2) != 0) begin
					r = stray_fields();
					r.mode = MODE_CLEAR;
					add_row(r);
					counted++;
				end
				if (first)
					nloads = TABLE_DEPTH + 6;
				else if ($urandom_range(0, 9) == 0)
					nloads = $urandom_range(40, TABLE_DEPTH + 8);
				else
					nloads = $urandom_range(0, 10);
				narrow = 1'($urandom_range(0, 1));
				base = ID_W'($urandom);
				repeat (nloads) begin
					r = stray_fields();
					r.mode = MODE_LOAD;
					r.load_id = narrow ? base + ID_W'($urandom_range(0, 63)) : pick_value();
					last_size = r.load_size;
					add_row(r);
					counted++;
				end
				nq = $urandom_range(1, 6);
				repeat (nq) begin
					r = stray_fields();
					r.mode = MODE_QUERY;
					r.want_id = narrow ? base + ID_W'($urandom_range(0, 63)) : pick_value();
					if ($urandom_range(0, 3) == 0)
						r.want_min_size = last_size;
					add_row(r);
					counted++;
				end
				first = 1'b0;
			end
		end
	endfunction

	// sender: bursts of random length separated by random gaps
	initial begin
		int sent;
		int burst_left;
		int gap_left;
		item_ch.valid         = 1'b0;
		item_ch.mode          = '0;
		item_ch.load_id       = '0;
		item_ch.load_size     = '0;
		item_ch.want_id       = '0;
		item_ch.want_min_size = '0;
		build_stimulus();
		sent = 0;
		burst_left = 0;
		gap_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (item_ch.valid && item_ch.ready)
				sent++;
			else if (item_ch.valid)
				continue;
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (sent < stimulus.size()) begin
				item_ch.valid         <= 1'b1;
				item_ch.mode          <= stimulus[sent].mode;
				item_ch.load_id       <= stimulus[sent].load_id;
				item_ch.load_size     <= stimulus[sent].load_size;
				item_ch.want_id       <= stimulus[sent].want_id;
				item_ch.want_min_size <= stimulus[sent].want_min_size;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					case ($urandom_range(0, 3))
						0: begin
							gap_left = 0;
							burst_left = $urandom_range(16, 40);
						end
						1: gap_left = $urandom_range(1, 3);
						2: gap_left = $urandom_range(0, 1);
						default: gap_left = $urandom_range(8, 30);
					endcase
				end
			end else begin
				item_ch.valid <= 1'b0;
				break;
			end
		end
		while (taken < stimulus.size() || pending_answers.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// receiver: stall pattern of its own, plus one long hold-off
	initial begin
		int hold_left;
		int phase_left;
		int style;
		bit hold_done;
		result_ch.ready = 1'b0;
		hold_left = 0;
		phase_left = 0;
		style = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					style = $urandom_range(0, 2);
					phase_left = $urandom_range(20, 120);
				end
				phase_left--;
				case (style)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					default: result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		request_t req;
		answer_t  want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				req = stimulus[taken];
				taken++;
				case (req.mode)
					MODE_LOAD: begin
						if (key_count < TABLE_DEPTH) begin
							key_ids[key_count]   = req.load_id;
							key_sizes[key_count] = req.load_size;
							key_count++;
						end
					end
					MODE_CLEAR: key_count = 0;
					MODE_QUERY: begin
						if (req.fixed)
							want = '{found: req.fix_found, best_id: req.fix_best_id};
						else
							want = nearest_fit(req.want_id, req.want_min_size);
						pending_answers = {pending_answers, want};
					end
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				if (pending_answers.size() == 0) begin
					$error("unexpected result beat: found %0d, best_id %h",
						result_ch.found, result_ch.best_id);
					fail_count++;
				end else begin
					want = pending_answers.pop_front();
					if (result_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, result_ch.found);
						fail_count++;
					end
					if (result_ch.best_id !== want.best_id) begin
						$error("best_id: expected %h, got %h", want.best_id, result_ch.best_id);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

// ===== closest_key_with_min_size.f =====
hdl/ckms_pkg.sv
hdl/ckms_if.sv
hdl/ckms_ram.sv
hdl/ckms_scan.sv
hdl/closest_key_with_min_size.sv
tb/tb_closest_key_with_min_size.sv
